/* sv/double_ended_queue_defines.svh */
// Assertion macros for the double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define DEQ_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check that cond holds in the cycle after trig.
`define DEQ_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* sv/deq_pkg.sv */
// Shared types and codes for the double-ended queue.
package deq_pkg;

	typedef logic signed [31:0] data_t;
	typedef logic [2:0] action_t;
	typedef logic [1:0] status_t;

	localparam action_t ACT_PUSH_FRONT = 3'd0;
	localparam action_t ACT_PUSH_BACK  = 3'd1;
	localparam action_t ACT_POP_FRONT  = 3'd2;
	localparam action_t ACT_POP_BACK   = 3'd3;
	localparam action_t ACT_LIST       = 3'd4;
	localparam action_t ACT_CLEAR      = 3'd5;

	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// Operation broadcast to every cell; at most one bit is set.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic rotate;
		logic clear;
	} cell_cmd_t;

endpackage

/* sv/double_ended_queue.sv */
// Top level of the double-ended queue: cell row, control and output register.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one action and a value per
//    transaction: push front, push back, pop front, pop back, list, clear.
//    Codes 6 and 7 are accepted and dropped without a result.
//  - Output channel (out_valid/out_ready) carries value_out, status and last.
//    Every action gives one result except list on a non-empty queue, which
//    gives one result per stored entry, front to back, last set on the final.
//  - Entries live in a row of DEPTH cells, front at cell 0. Push front and
//    pop front shift the whole row by one cell; push back fills only the cell
//    after the tail and pop back empties only the tail cell. List rotates the
//    row one cell per cycle while not stalled; count steps restore its order.
//  - A push, pop, clear or empty-list result appears in the cycle after its
//    transaction is accepted; a list first sets listing_q, then loads the
//    entries into the output register in turn as each held result is taken.
//    A new push, pop or clear is accepted whenever the output register can
//    take a result; during a list in_ready is low until the last entry.
//  - A stalled receiver holds the output register; in_ready drops until the
//    held result is taken, so nothing is lost or repeated.
//  - Reset empties the queue at once; no clearing pass is needed.
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  deq_pkg::action_t action,
	input  deq_pkg::data_t   value,
	output logic             out_valid,
	input  logic             out_ready,
	output deq_pkg::data_t   value_out,
	output deq_pkg::status_t status,
	output logic             last
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	// Cell row
	data_t     cell_data  [DEPTH];
	logic      cell_valid [DEPTH];
	data_t     right_data [DEPTH];
	logic      right_valid[DEPTH];
	cell_cmd_t cmd;
	logic [DEPTH-1:0] occupied;

	// Control state
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          listing_q;
	logic [CW-1:0] left_q;
	logic          start_list;

	// Output register
	logic    out_valid_q;
	data_t   value_out_q;
	status_t status_q;
	logic    last_q;

	logic    take;
	logic    in_fire;
	logic    list_step;
	logic    full;
	logic    empty;
	data_t   tail_data;
	logic    load;
	data_t   ld_value;
	status_t ld_status;
	logic    ld_last;

	// Build the row: cell 0 sees the pushed value on its left, the end cell
	// sees an empty neighbor on its right.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		data_t left_data;
		logic  left_valid;

		if (g == 0) begin : g_head
			assign left_data  = value;
			assign left_valid = 1'b1;
		end else begin : g_body
			assign left_data  = cell_data[g-1];
			assign left_valid = cell_valid[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign right_data[g]  = '0;
			assign right_valid[g] = 1'b0;
		end else begin : g_mid
			assign right_data[g]  = cell_data[g+1];
			assign right_valid[g] = cell_valid[g+1];
		end

		deq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.push_value (value),
			.left_data  (left_data),
			.left_valid (left_valid),
			.right_data (right_data[g]),
			.right_valid(right_valid[g]),
			.head_data  (cell_data[0]),
			.data_q     (cell_data[g]),
			.valid_q    (cell_valid[g])
		);
	end

	// Select the tail entry: the one occupied cell whose right neighbor is empty.
	always_comb begin
		tail_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cell_valid[i] && !right_valid[i]) begin
				tail_data = tail_data | cell_data[i];
			end
		end
	end

	// Gather the occupied flags into one vector for the checks below.
	always_comb begin
		occupied = '0;
		for (int i = 0; i < DEPTH; i++) begin
			occupied[i] = cell_valid[i];
		end
	end

	assign full      = cell_valid[DEPTH-1];
	assign empty     = !cell_valid[0];
	assign take      = !out_valid_q || out_ready;
	assign in_ready  = !listing_q && take;
	assign in_fire   = in_valid && in_ready;
	assign list_step = listing_q && take;

	// Decode the transaction into a row command and a result.
	always_comb begin
		cmd        = '0;
		count_d    = count_q;
		start_list = 1'b0;
		load       = 1'b0;
		ld_value   = '0;
		ld_status  = ST_DONE;
		ld_last    = 1'b1;
		if (list_step) begin
			// emit the head and rotate it to the tail
			cmd.rotate = 1'b1;
			load       = 1'b1;
			ld_value   = cell_data[0];
			ld_last    = (left_q == CW'(1));
		end else if (in_fire) begin
			unique case (action)
				ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
					load = 1'b1;
					if (full) begin
						ld_status = ST_FULL;
					end else begin
						cmd.push_front = (action == ACT_PUSH_FRONT);
						cmd.push_back  = (action == ACT_PUSH_BACK);
						count_d        = count_q + CW'(1);
					end
				end
				ACT_POP_FRONT, ACT_POP_BACK: begin
					load = 1'b1;
					if (empty) begin
						ld_status = ST_EMPTY;
					end else begin
						cmd.pop_front = (action == ACT_POP_FRONT);
						cmd.pop_back  = (action == ACT_POP_BACK);
						ld_value      = (action == ACT_POP_FRONT) ? cell_data[0] : tail_data;
						count_d       = count_q - CW'(1);
					end
				end
				ACT_LIST: begin
					if (empty) begin
						load      = 1'b1;
						ld_status = ST_EMPTY;
					end else begin
						start_list = 1'b1;
					end
				end
				ACT_CLEAR: begin
					cmd.clear = 1'b1;
					load      = 1'b1;
					count_d   = '0;
				end
				default: begin
					// unused codes: drop the transaction
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			listing_q   <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (start_list) begin
				listing_q <= 1'b1;
				left_q    <= count_q;
			end else if (list_step) begin
				left_q <= left_q - CW'(1);
				if (left_q == CW'(1)) begin
					listing_q <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload of the output register; hold while the receiver stalls.
	always_ff @(posedge clk) begin
		if (load) begin
			value_out_q <= ld_value;
			status_q    <= ld_status;
			last_q      <= ld_last;
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_out_q;
	assign status    = status_q;
	assign last      = last_q;

	// Assertions
	`DEQ_ASSERT_SAME(a_count_range, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
	`DEQ_ASSERT_SAME(a_count_row, 1'b1, $countones(occupied) == int'(count_q), "count mismatch")
	`DEQ_ASSERT_SAME(a_list_block, listing_q, !in_ready, "input taken during list")
	`DEQ_ASSERT_NEXT(a_list_end, list_step && left_q == CW'(1), !listing_q && last_q, "list end")

endmodule

/* sv/deq_cell.sv */
// One storage cell of the queue row: an entry and its occupied flag.
module deq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  deq_pkg::cell_cmd_t cmd,
	input  deq_pkg::data_t    push_value,
	input  deq_pkg::data_t    left_data,
	input  logic              left_valid,
	input  deq_pkg::data_t    right_data,
	input  logic              right_valid,
	input  deq_pkg::data_t    head_data,
	output deq_pkg::data_t    data_q,
	output logic              valid_q
);
	import deq_pkg::*;

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= left_data;
		end else if (cmd.push_back && !valid_q && left_valid) begin
			data_q <= push_value;
		end else if (cmd.pop_front) begin
			data_q <= right_data;
		end else if (cmd.rotate && valid_q) begin
			// the tail wraps around to take the old head
			data_q <= right_valid ? right_data : head_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.push_front) begin
			valid_q <= left_valid;
		end else if (cmd.push_back) begin
			valid_q <= valid_q | left_valid;
		end else if (cmd.pop_front) begin
			valid_q <= right_valid;
		end else if (cmd.pop_back) begin
			valid_q <= valid_q & right_valid;
		end
	end

endmodule
